/* src/foc_pkg.sv */
package foc_pkg;

  // frame store geometry
  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 256;
  localparam int FRAME_COUNT = 2;
  localparam int FRAME_SIZE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int FRAME_AW    = $clog2(FRAME_SIZE);
  localparam int FSEL_W      = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int MEM_DEPTH   = FRAME_COUNT * FRAME_SIZE;
  localparam int MEM_AW      = FSEL_W + FRAME_AW;
  localparam int X_W         = $clog2(MAX_WIDTH);
  localparam int Y_W         = $clog2(MAX_HEIGHT);

  // field widths
  localparam int OPC_W      = 2;
  localparam int COORD_W    = 12;
  localparam int RAD_W      = 11;
  localparam int PIX_W      = 8;
  localparam int ADDR_W     = 17;
  localparam int COUNT_W    = 18;
  localparam int WID_W      = 10;
  localparam int HGT_W      = 9;
  localparam int FRM_W      = 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // signed span arithmetic and square root widths
  localparam int SW   = 14;
  localparam int SQ_W = 2 * RAD_W;

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(320);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(256);

  typedef enum logic [OPC_W-1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FRAME  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_ROW,
    ST_SQRT,
    ST_SPAN,
    ST_PIXEL,
    ST_NEXT_ROW,
    ST_CHECK_RD,
    ST_READ_MEM,
    ST_READ_TAKE,
    ST_CHECK_WR,
    ST_WRITE_MEM,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic setup;
    logic row_start;
    logic sq_step;
    logic span;
    logic pix_step;
    logic y_next;
    logic check;
    logic rd_op;
    logic rd_take;
    logic wr_op;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic draw_empty;
    logic sq_last;
    logic span_empty;
    logic x_last;
    logic y_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* src/foc_frame_mem.sv */
module foc_frame_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [foc_pkg::MEM_AW-1:0]  waddr,
  input  logic [foc_pkg::PIX_W-1:0]   wdata,
  input  logic                        re,
  input  logic [foc_pkg::MEM_AW-1:0]  raddr,
  output logic [foc_pkg::PIX_W-1:0]   rdata
);
  import foc_pkg::*;

  logic [PIX_W-1:0] mem [MEM_DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/foc_ctrl.sv */
module foc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [foc_pkg::OPC_W-1:0]  in_opcode,
  output logic                       in_ready,
  input  foc_pkg::ctrl_stat_t        stat,
  output foc_pkg::ctrl_cmd_t         cmd
);
  import foc_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_opcode))
            OP_DRAW:  state_nxt = ST_SETUP;
            OP_READ:  state_nxt = ST_CHECK_RD;
            OP_WRITE: state_nxt = ST_CHECK_WR;
            default:  state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SETUP: begin
        state_nxt = stat.draw_empty ? ST_FINISH : ST_ROW;
      end
      ST_ROW: begin
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (stat.sq_last) state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        state_nxt = stat.span_empty ? ST_NEXT_ROW : ST_PIXEL;
      end
      ST_PIXEL: begin
        if (stat.x_last) state_nxt = ST_NEXT_ROW;
      end
      ST_NEXT_ROW: begin
        state_nxt = stat.y_last ? ST_FINISH : ST_ROW;
      end
      ST_CHECK_RD: begin
        state_nxt = ST_READ_MEM;
      end
      ST_READ_MEM: begin
        state_nxt = ST_READ_TAKE;
      end
      ST_READ_TAKE: begin
        state_nxt = ST_FINISH;
      end
      ST_CHECK_WR: begin
        state_nxt = ST_WRITE_MEM;
      end
      ST_WRITE_MEM: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load = accept;
    case (state_r)
      ST_CLEAR:     cmd.clr_step  = 1'b1;
      ST_SETUP:     cmd.setup     = 1'b1;
      ST_ROW:       cmd.row_start = 1'b1;
      ST_SQRT:      cmd.sq_step   = 1'b1;
      ST_SPAN:      cmd.span      = 1'b1;
      ST_PIXEL:     cmd.pix_step  = 1'b1;
      ST_NEXT_ROW:  cmd.y_next    = 1'b1;
      ST_CHECK_RD:  cmd.check     = 1'b1;
      ST_CHECK_WR:  cmd.check     = 1'b1;
      ST_READ_MEM:  cmd.rd_op     = 1'b1;
      ST_READ_TAKE: cmd.rd_take   = 1'b1;
      ST_WRITE_MEM: cmd.wr_op     = 1'b1;
      ST_FINISH:    cmd.out_load  = stat.out_free;
      default:      cmd.load      = accept;
    endcase
  end

endmodule

/* src/foc_dp.sv */
module foc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  foc_pkg::ctrl_cmd_t              cmd,
  output foc_pkg::ctrl_stat_t             stat,
  input  logic                            cfg_valid,
  input  logic [foc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [foc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic signed [foc_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [foc_pkg::COORD_W-1:0] in_center_y,
  input  logic [foc_pkg::RAD_W-1:0]       in_radius,
  input  logic [foc_pkg::PIX_W-1:0]       in_or_mask,
  input  logic [foc_pkg::ADDR_W-1:0]      in_pixel_addr,
  input  logic [foc_pkg::PIX_W-1:0]       in_write_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [foc_pkg::PIX_W-1:0]       out_read_data,
  output logic [foc_pkg::COUNT_W-1:0]     out_pixels_written
);
  import foc_pkg::*;

  // configuration
  logic [WID_W-1:0]  width_r;
  logic [HGT_W-1:0]  height_r;
  logic [FRM_W-1:0]  frame_r;
  logic [WID_W-1:0]  eff_w;
  logic [HGT_W-1:0]  eff_h;
  logic [FSEL_W-1:0] frame_sel;

  // latched item
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic [RAD_W-1:0]  rad_r;
  logic [PIX_W-1:0]  mask_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PIX_W-1:0]  wdata_r;

  // draw state
  logic [SQ_W-1:0]     r2_r;
  logic [Y_W-1:0]      y_r, y1_r;
  logic [FRAME_AW-1:0] row_base_r;
  logic [SQ_W-1:0]     rem_r, res_r, bit_r;
  logic [X_W-1:0]      x_r, x1_r;
  logic                pend_r;
  logic [MEM_AW-1:0]   pend_addr_r;
  logic [COUNT_W-1:0]  count_r;
  logic                in_range_r;
  logic [PIX_W-1:0]    rd_data_r;
  logic [MEM_AW-1:0]   clr_addr_r;

  // result register
  logic                out_valid_r;
  logic [PIX_W-1:0]    out_read_data_r;
  logic [COUNT_W-1:0]  out_count_r;

  // combinational
  logic signed [SW-1:0] cx_s, cy_s, rad_s, y0_s, y1_s, ylim_s, y0c_s, y1c_s;
  logic signed [SW-1:0] dy_s, dy_abs_s, half_s, x0_s, x1_s, xlim_s, x0c_s, x1c_s;
  logic [RAD_W-1:0]     dy_mag;
  logic [SQ_W-1:0]      dy2, sq_try;
  logic [COUNT_W-1:0]   wh;
  logic [MEM_AW-1:0]    pix_addr, op_addr;
  logic                 mem_we, mem_re;
  logic [MEM_AW-1:0]    mem_waddr, mem_raddr;
  logic [PIX_W-1:0]     mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      frame_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        CFG_FRAME:  frame_r  <= cfg_data[FRM_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      eff_w = WID_W'(1);
    end else if (width_r > WID_W'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = HGT_W'(1);
    end else if (height_r > HGT_W'(MAX_HEIGHT)) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  assign frame_sel = (int'(frame_r) >= FRAME_COUNT) ? FSEL_W'(FRAME_COUNT - 1)
                                                    : FSEL_W'(frame_r);

  // row range of the circle and column span of the current row, clipped to the screen
  always_comb begin
    cx_s   = SW'(cx_r);
    cy_s   = SW'(cy_r);
    rad_s  = $signed(SW'(rad_r));
    ylim_s = $signed(SW'(eff_h - HGT_W'(1)));
    xlim_s = $signed(SW'(eff_w - WID_W'(1)));
    y0_s   = cy_s - rad_s;
    y1_s   = cy_s + rad_s;
    y0c_s  = y0_s[SW-1] ? '0 : y0_s;
    y1c_s  = (y1_s > ylim_s) ? ylim_s : y1_s;

    dy_s     = $signed(SW'(y_r)) - cy_s;
    dy_abs_s = dy_s[SW-1] ? -dy_s : dy_s;
    dy_mag   = dy_abs_s[RAD_W-1:0];
    dy2      = SQ_W'(dy_mag) * SQ_W'(dy_mag);

    sq_try = res_r + bit_r;

    half_s = $signed(SW'(res_r[RAD_W-1:0]));
    x0_s   = cx_s - half_s;
    x1_s   = cx_s + half_s;
    x0c_s  = x0_s[SW-1] ? '0 : x0_s;
    x1c_s  = (x1_s > xlim_s) ? xlim_s : x1_s;
  end

  assign wh       = COUNT_W'(eff_w) * COUNT_W'(eff_h);
  assign pix_addr = {frame_sel, row_base_r + FRAME_AW'(x_r)};
  assign op_addr  = {frame_sel, FRAME_AW'(addr_r)};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      rad_r   <= in_radius;
      mask_r  <= in_or_mask;
      addr_r  <= in_pixel_addr;
      wdata_r <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count_r   <= '0;
      rd_data_r <= '0;
    end else begin
      if (cmd.pix_step) count_r <= count_r + COUNT_W'(1);
      if (cmd.rd_take) rd_data_r <= in_range_r ? mem_rdata : '0;
    end
    if (cmd.setup) begin
      r2_r <= SQ_W'(rad_r) * SQ_W'(rad_r);
      y_r  <= y0c_s[Y_W-1:0];
      y1_r <= y1c_s[Y_W-1:0];
    end else if (cmd.y_next) begin
      y_r <= y_r + Y_W'(1);
    end
    if (cmd.row_start) begin
      rem_r      <= r2_r - dy2;
      res_r      <= '0;
      bit_r      <= SQ_W'(1) << (SQ_W - 2);
      row_base_r <= FRAME_AW'(y_r) * FRAME_AW'(eff_w);
    end else if (cmd.sq_step) begin
      // one result bit per cycle
      if (rem_r >= sq_try) begin
        rem_r <= rem_r - sq_try;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.span) begin
      x_r  <= x0c_s[X_W-1:0];
      x1_r <= x1c_s[X_W-1:0];
    end else if (cmd.pix_step) begin
      x_r <= x_r + X_W'(1);
    end
    if (cmd.pix_step) pend_addr_r <= pix_addr;
    if (cmd.check) in_range_r <= COUNT_W'(addr_r) < wh;
  end

  // pixel read issued one cycle, or-write of the same pixel the next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      pend_r <= cmd.pix_step;
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + MEM_AW'(1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = mem_rdata | mask_r;
    end else if (cmd.wr_op) begin
      mem_we    = in_range_r;
      mem_waddr = op_addr;
      mem_wdata = wdata_r;
    end
    mem_re    = cmd.pix_step || cmd.rd_op;
    mem_raddr = cmd.pix_step ? pix_addr : op_addr;
  end

  foc_frame_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_data_r <= rd_data_r;
      out_count_r     <= count_r;
    end
  end

  always_comb begin
    stat.clr_last   = (clr_addr_r == MEM_AW'(MEM_DEPTH - 1));
    stat.draw_empty = (y0c_s > y1c_s);
    stat.sq_last    = bit_r[0];
    stat.span_empty = (x0c_s > x1c_s);
    stat.x_last     = (x_r == x1_r);
    stat.y_last     = (y_r == y1_r);
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_pixels_written = out_count_r;

endmodule

/* src/filled_circle_or_fill.sv */
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | opcode, center, radius, mask, addr, data
// out     | output    | out_valid / out_ready | read_data, pixels_written
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// draw: setup, then per visible row a row start, the 11-step bit-serial square root,
// a span step and the covered pixels, one read-modify-write a cycle, then a row step;
// a read passes check, memory read and take, a write check and memory write, both
// then finish, where an unused opcode goes straight; after reset the frame store is
// swept to zero, one byte a cycle, in_ready low; a finished word waits in the output
// register while the next word is taken, whose result waits until the register frees
module filled_circle_or_fill (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [foc_pkg::OPC_W-1:0]          in_opcode,
  input  logic signed [foc_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [foc_pkg::COORD_W-1:0] in_center_y,
  input  logic [foc_pkg::RAD_W-1:0]          in_radius,
  input  logic [foc_pkg::PIX_W-1:0]          in_or_mask,
  input  logic [foc_pkg::ADDR_W-1:0]         in_pixel_addr,
  input  logic [foc_pkg::PIX_W-1:0]          in_write_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [foc_pkg::PIX_W-1:0]          out_read_data,
  output logic [foc_pkg::COUNT_W-1:0]        out_pixels_written,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [foc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [foc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import foc_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  foc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  foc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_center_x        (in_center_x),
    .in_center_y        (in_center_y),
    .in_radius          (in_radius),
    .in_or_mask         (in_or_mask),
    .in_pixel_addr      (in_pixel_addr),
    .in_write_data      (in_write_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_pixels_written (out_pixels_written)
  );

endmodule

/* test/foc_checker.sv */
module foc_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [foc_pkg::OPC_W-1:0]          in_opcode,
  input  logic signed [foc_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [foc_pkg::COORD_W-1:0] in_center_y,
  input  logic [foc_pkg::RAD_W-1:0]          in_radius,
  input  logic [foc_pkg::PIX_W-1:0]          in_or_mask,
  input  logic [foc_pkg::ADDR_W-1:0]         in_pixel_addr,
  input  logic [foc_pkg::PIX_W-1:0]          in_write_data,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [foc_pkg::PIX_W-1:0]          out_read_data,
  input  logic [foc_pkg::COUNT_W-1:0]        out_pixels_written,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [foc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [foc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 mismatches,
  output int                                 waiting
);
  import foc_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]   read_data;
    logic [COUNT_W-1:0] pixels_written;
  } answer_t;

  answer_t answer_q[$];
  answer_t want;

  // shadow frame store, zero from time 0 like the cleared store
  bit [PIX_W-1:0] pixel_mem [MEM_DEPTH];

  logic [WID_W-1:0] width_reg;
  logic [HGT_W-1:0] height_reg;
  logic [FRM_W-1:0] frame_reg;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int i = 11; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic answer_t paint_or_access(input logic [OPC_W-1:0] op, input int cx,
                                              input int cy, input int r,
                                              input logic [PIX_W-1:0] mask, input int addr,
                                              input logic [PIX_W-1:0] wdata);
    int w, h, base, y0, y1, x0, x1, dy, half, row, covered;
    answer_t a;
    a = '0;
    covered = 0;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : int'(width_reg));
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : int'(height_reg));
    base = (int'(frame_reg) >= FRAME_COUNT ? FRAME_COUNT - 1 : int'(frame_reg)) * FRAME_SIZE;
    case (op_t'(op))
      OP_DRAW: begin
        y0 = (cy - r < 0) ? 0 : cy - r;
        y1 = (cy + r > h - 1) ? h - 1 : cy + r;
        for (int y = y0; y <= y1; y++) begin
          dy = y - cy;
          half = int'(floor_root(r * r - dy * dy));
          x0 = (cx - half < 0) ? 0 : cx - half;
          x1 = (cx + half > w - 1) ? w - 1 : cx + half;
          row = base + y * w;
          for (int x = x0; x <= x1; x++) begin
            pixel_mem[row + x] |= mask;
            covered++;
          end
        end
        a.pixels_written = COUNT_W'(covered);
      end
      OP_READ: begin
        if (addr < w * h) a.read_data = pixel_mem[base + addr];
      end
      OP_WRITE: begin
        if (addr < w * h) pixel_mem[base + addr] = wdata;
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      frame_reg  = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:  width_reg = cfg_data[WID_W-1:0];
          CFG_HEIGHT: height_reg = cfg_data[HGT_W-1:0];
          CFG_FRAME:  frame_reg = cfg_data[FRM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result word with no command outstanding");
        end else begin
          want = answer_q.pop_front();
          if (out_read_data !== want.read_data)
            report_mismatch($sformatf("read_data got %0d want %0d",
                                      out_read_data, want.read_data));
          if (out_pixels_written !== want.pixels_written)
            report_mismatch($sformatf("pixels_written got %0d want %0d",
                                      out_pixels_written, want.pixels_written));
        end
      end
      if (in_valid && in_ready)
        answer_q.push_back(paint_or_access(in_opcode, int'(in_center_x),
                                           int'(in_center_y), int'(in_radius),
                                           in_or_mask, int'(in_pixel_addr),
                                           in_write_data));
    end
    waiting = answer_q.size();
  end

endmodule

/* test/tb_filled_circle_or_fill.sv */
module tb_filled_circle_or_fill;
  import foc_pkg::*;

  localparam logic [OPC_W-1:0]     OP_UNUSED       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 2'd3;
  localparam int                   WORDS_PER_PHASE = 29;
  localparam int                   HOLD_CYCLES     = 600;
  localparam int                   CYCLE_LIMIT     = 4_000_000;

  typedef struct {
    logic [OPC_W-1:0]          op;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          r;
    logic [PIX_W-1:0]          mask;
    logic [ADDR_W-1:0]         addr;
    logic [PIX_W-1:0]          wdata;
  } cmd_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [OPC_W-1:0]          in_opcode;
  logic signed [COORD_W-1:0] in_center_x;
  logic signed [COORD_W-1:0] in_center_y;
  logic [RAD_W-1:0]          in_radius;
  logic [PIX_W-1:0]          in_or_mask;
  logic [ADDR_W-1:0]         in_pixel_addr;
  logic [PIX_W-1:0]          in_write_data;
  logic                      out_valid;
  logic                      out_ready;
  logic [PIX_W-1:0]          out_read_data;
  logic [COUNT_W-1:0]        out_pixels_written;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  int                        mismatches;
  int                        waiting;

  int eff_w = 320;
  int eff_h = 256;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int words_sent = 0;
  int draws_sent = 0;
  int cfg_writes = 0;
  int spot_q[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  filled_circle_or_fill u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_center_x        (in_center_x),
    .in_center_y        (in_center_y),
    .in_radius          (in_radius),
    .in_or_mask         (in_or_mask),
    .in_pixel_addr      (in_pixel_addr),
    .in_write_data      (in_write_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_pixels_written (out_pixels_written),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  foc_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_center_x        (in_center_x),
    .in_center_y        (in_center_y),
    .in_radius          (in_radius),
    .in_or_mask         (in_or_mask),
    .in_pixel_addr      (in_pixel_addr),
    .in_write_data      (in_write_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_pixels_written (out_pixels_written),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .waiting            (waiting)
  );

  // entered and left at a falling edge
  task automatic send_word(input cmd_t c);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_opcode     = c.op;
    in_center_x   = c.cx;
    in_center_y   = c.cy;
    in_radius     = c.r;
    in_or_mask    = c.mask;
    in_pixel_addr = c.addr;
    in_write_data = c.wdata;
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (c.op == OP_DRAW) draws_sent++;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    int v;
    settle();
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
    if (idx == CFG_WIDTH) begin
      v = int'(value[WID_W-1:0]);
      eff_w = (v == 0) ? 1 : (v > MAX_WIDTH ? MAX_WIDTH : v);
    end else if (idx == CFG_HEIGHT) begin
      v = int'(value[HGT_W-1:0]);
      eff_h = (v == 0) ? 1 : (v > MAX_HEIGHT ? MAX_HEIGHT : v);
    end
    // remembered addresses belong to the old geometry or frame
    spot_q.delete();
  endtask

  function automatic cmd_t make_word(input logic [OPC_W-1:0] op, input int cx, input int cy,
                                     input int r, input logic [PIX_W-1:0] mask,
                                     input int addr, input logic [PIX_W-1:0] wdata);
    cmd_t c;
    c.op    = op;
    c.cx    = COORD_W'(cx);
    c.cy    = COORD_W'(cy);
    c.r     = RAD_W'(r);
    c.mask  = mask;
    c.addr  = ADDR_W'(addr);
    c.wdata = wdata;
    return c;
  endfunction

  function automatic void note_spot(input int addr);
    spot_q.push_back(addr);
    if (spot_q.size() > 16) void'(spot_q.pop_front());
  endfunction

  function automatic int pick_addr(input int area);
    int k;
    k = $urandom_range(99);
    if (k < 55 && spot_q.size() > 0) return spot_q[$urandom_range(spot_q.size() - 1)];
    if (k < 90) return $urandom_range(area - 1);
    return $urandom_range((1 << ADDR_W) - 1);
  endfunction

  task automatic random_word();
    cmd_t c;
    int pick;
    int kind;
    int area;
    c.op    = OPC_W'($urandom);
    c.cx    = COORD_W'($urandom);
    c.cy    = COORD_W'($urandom);
    c.r     = RAD_W'($urandom);
    c.mask  = PIX_W'($urandom);
    c.addr  = ADDR_W'($urandom);
    c.wdata = PIX_W'($urandom);
    area = eff_w * eff_h;
    pick = $urandom_range(99);
    if (pick < 35) begin
      c.op = OP_DRAW;
      kind = $urandom_range(99);
      if (kind < 70) begin
        c.r  = RAD_W'($urandom_range(24));
        c.cx = COORD_W'(int'($urandom_range(eff_w + 20)) - 10);
        c.cy = COORD_W'(int'($urandom_range(eff_h + 20)) - 10);
        if (c.cx >= 0 && c.cx < eff_w && c.cy >= 0 && c.cy < eff_h)
          note_spot(c.cy * eff_w + c.cx);
      end else if (kind < 90) begin
        // centre anywhere in the coordinate range, mostly off screen
        c.r = RAD_W'($urandom_range(16));
      end else begin
        // huge disc whose bottom edge just grazes the top rows
        c.r  = RAD_W'($urandom_range(2047, 64));
        c.cy = COORD_W'(int'($urandom_range(6)) - int'(c.r));
      end
    end else if (pick < 67) begin
      c.op   = OP_READ;
      c.addr = ADDR_W'(pick_addr(area));
    end else if (pick < 96) begin
      c.op   = OP_WRITE;
      c.addr = ADDR_W'(pick_addr(area));
      if (int'(c.addr) < area) note_spot(int'(c.addr));
    end else begin
      c.op = OP_UNUSED;
    end
    send_word(c);
  endtask

  initial begin
    int hold_left;
    int hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words still outstanding", cycles, waiting);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = '0;
    in_center_x   = '0;
    in_center_y   = '0;
    in_radius     = '0;
    in_or_mask    = '0;
    in_pixel_addr = '0;
    in_write_data = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset geometry 320x256, frame 0
    send_word(make_word(OP_WRITE, 0, 0, 0, 8'h00, 0, 8'hA5));
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 0, 8'h00));
    send_word(make_word(OP_WRITE, 0, 0, 0, 8'h00, 81919, 8'hFF));
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 81919, 8'h00));
    send_word(make_word(OP_WRITE, 0, 0, 0, 8'h00, 81920, 8'h77));
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 81920, 8'h00));
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 131071, 8'h00));
    // single pixel disc whose OR leaves the value unchanged
    send_word(make_word(OP_DRAW, 0, 0, 0, 8'h01, 0, 8'h00));
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 0, 8'h00));
    send_word(make_word(OP_DRAW, 10, 10, 3, 8'h80, 0, 8'h00));
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 3210, 8'h00));
    send_word(make_word(OP_DRAW, -2048, -2048, 2047, 8'hFF, 0, 8'h00));
    send_word(make_word(OP_DRAW, 2047, 2047, 0, 8'hFF, 0, 8'h00));
    send_word(make_word(OP_DRAW, -2, 5, 4, 8'h0F, 0, 8'h00));
    send_word(make_word(OP_DRAW, 319, 255, 5, 8'hF0, 0, 8'h00));
    send_word(make_word(OP_UNUSED, 1234, -77, 99, 8'h3C, 131071, 8'hC3));
    // covers the whole screen
    send_word(make_word(OP_DRAW, 160, 128, 2047, 8'h40, 0, 8'h00));
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 81919, 8'h00));

    // zero width and height act as a 1x1 screen
    set_reg(CFG_WIDTH, 10'd0);
    set_reg(CFG_HEIGHT, 10'd0);
    set_reg(CFG_FRAME, 10'd1);
    set_reg(CFG_SPARE, 10'h3FF);
    send_word(make_word(OP_DRAW, 0, 0, 5, 8'h3C, 0, 8'h00));
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 1, 8'h00));
    send_word(make_word(OP_WRITE, 0, 0, 0, 8'h00, 0, 8'h5A));
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 0, 8'h00));
    set_reg(CFG_FRAME, 10'd0);
    set_reg(CFG_WIDTH, 10'd320);
    set_reg(CFG_HEIGHT, 10'd256);
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 0, 8'h00));
    send_word(make_word(OP_READ, 0, 0, 0, 8'h00, 3210, 8'h00));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          // oversize values clamp to the full frame
          set_reg(CFG_WIDTH, 10'h3FF);
          set_reg(CFG_HEIGHT, 10'h1FF);
          set_reg(CFG_FRAME, 10'd1);
          gap_pct   = 0;
          stall_pct = 0;
          // long output hold while words keep coming
          hold_asks++;
        end
        1: begin
          set_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(MAX_WIDTH, 1)));
          set_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(MAX_HEIGHT, 1)));
          set_reg(CFG_FRAME, CFG_DATA_W'($urandom));
          gap_pct   = 78;
          stall_pct = 0;
        end
        2: begin
          set_reg(CFG_WIDTH, 10'd64);
          set_reg(CFG_HEIGHT, 10'd48);
          set_reg(CFG_FRAME, 10'd0);
          gap_pct   = 0;
          stall_pct = 78;
        end
        default: begin
          set_reg(CFG_WIDTH, 10'd320);
          set_reg(CFG_HEIGHT, 10'd256);
          set_reg(CFG_FRAME, 10'd1);
          gap_pct   = 13;
          stall_pct = 13;
        end
      endcase
      repeat (WORDS_PER_PHASE) random_word();
    end

    settle();
    repeat (16) @(negedge clk);
    $display("sent %0d words (%0d circle draws) and %0d register writes", words_sent,
             draws_sent, cfg_writes);
    $display("screens from 1x1 to 512x256 on both frames, under idle, stall and hold mixes");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/foc_pkg.sv
src/foc_frame_mem.sv
src/foc_ctrl.sv
src/foc_dp.sv
src/filled_circle_or_fill.sv
test/foc_checker.sv
test/tb_filled_circle_or_fill.sv
